### src/lsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the LRU sector cache
// Sizes, request codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package lsc_pkg;
	localparam int ENTRIES          = 16;
	localparam int SECTOR_BYTES     = 256;
	localparam int WORD_BYTES       = 8;
	localparam int WORDS_PER_SECTOR = (SECTOR_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int SLOT_W           = $clog2(ENTRIES);
	localparam int WIDX_W           = $clog2(WORDS_PER_SECTOR);
	localparam int MEM_DEPTH        = ENTRIES * WORDS_PER_SECTOR;
	localparam int ADDR_W           = $clog2(MEM_DEPTH);
	localparam int CNT_W            = $clog2(ENTRIES + 1);
	localparam int CMDQ_DEPTH       = 4;
	localparam int CMDQ_AW          = $clog2(CMDQ_DEPTH);

	typedef enum logic [1:0] {
		REQ_GET   = 2'd0,
		REQ_PUT   = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic                       is_get;   // else: put word to write
		logic                       hit;
		logic [SLOT_W-1:0]          slot;
		logic [8:0]                 length;
		logic [WIDX_W-1:0]          widx;
		logic [63:0]                data;
		logic                       start;    // first word: zero the slot first
		logic [31:0]                hit_count;
		logic [31:0]                miss_count;
		logic [4:0]                 occupancy;
	} cmd_t;
endpackage
`default_nettype wire

### src/lsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_front: lookup and replacement
// Keeps tags, lengths, LRU ranks and counters; classifies each request
// and issues commands for the data side.
// ----------------------------------------------------------------------------
module lsc_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire  [4:0]             cfg_wdata,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [1:0]             req_type,
	input  wire  [7:0]             track,
	input  wire  [7:0]             sector,
	input  wire  [4:0]             word_index,
	input  wire  [63:0]            data_word,
	input  wire  [8:0]             put_length,
	input  wire                    last_word,
	output logic                   cmd_valid,
	output lsc_pkg::cmd_t          cmd,
	input  wire                    cmd_ready
);
	import lsc_pkg::*;

	logic [ENTRIES-1:0]      valid_q;
	logic [15:0]             key_q  [ENTRIES];
	logic [8:0]              len_q  [ENTRIES];
	logic [SLOT_W-1:0]       rank_q [ENTRIES];
	logic [31:0]             hitc_q, missc_q;
	logic [SLOT_W-1:0]       open_q;
	logic                    active_q;
	logic [CNT_W-1:0]        cap_q;
	logic                    zeroing_q;   // slot zero pending: hold words

	logic [15:0]             key;
	logic [ENTRIES-1:0]      match;
	logic                    found;
	logic [SLOT_W-1:0]       found_slot, free_slot, lru_slot, sel_slot;
	logic                    has_free;
	logic [CNT_W-1:0]        occ;
	logic [CNT_W-1:0]        cap_new;
	logic                    take, is_put, is_get, put_start;
	logic [8:0]              len_sat;
	logic [SLOT_W-1:0]       put_slot;
	logic [8:0]              put_len;
	logic                    write_ok;
	logic [ENTRIES-1:0]      evict;
	logic [31:0]             hitc_n, missc_n;

	assign key = {track, sector};

	always_comb begin
		found = 1'b0; found_slot = '0; has_free = 1'b0; free_slot = '0;
		lru_slot = '0; occ = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key);
			if (valid_q[i]) occ = occ + CNT_W'(1);
			if (valid_q[i] && rank_q[i] == SLOT_W'(cap_q - CNT_W'(1)))
				lru_slot = SLOT_W'(i);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin found = 1'b1; found_slot = SLOT_W'(i); end
			if (!valid_q[i]) begin has_free = 1'b1; free_slot = SLOT_W'(i); end
		end
	end

	// With ranks dense 0..occ-1, the least recent holds rank occ-1 = cap-1 when full.
	always_comb begin
		priority if (found)                 sel_slot = found_slot;
		else if (occ < cap_q && has_free)   sel_slot = free_slot;
		else                                sel_slot = lru_slot;
	end

	assign is_put    = req_type == REQ_PUT;
	assign is_get    = req_type == REQ_GET;
	assign put_start = is_put && word_index == 5'd0;
	assign len_sat   = (put_length > 9'(SECTOR_BYTES)) ? 9'(SECTOR_BYTES) : put_length;
	assign put_slot  = put_start ? sel_slot : open_q;
	assign put_len   = put_start ? len_sat : len_q[open_q];
	assign write_ok  = (put_start || active_q) && ({1'b0, word_index} < 6'(WORDS_PER_SECTOR))
		&& ({4'd0, word_index} * 9'(WORD_BYTES) < put_len);

	assign in_ready = cmd_ready && !zeroing_q;
	assign take     = in_valid && in_ready;

	assign hitc_n  = (hitc_q  != '1 && found)  ? hitc_q + 32'd1  : hitc_q;
	assign missc_n = (missc_q != '1 && !found) ? missc_q + 32'd1 : missc_q;

	always_comb begin
		cmd_valid      = 1'b0;
		cmd            = '0;
		cmd.is_get     = is_get;
		cmd.hit        = found;
		cmd.slot       = is_get ? found_slot : put_slot;
		cmd.length     = is_get ? len_q[found_slot] : put_len;
		cmd.widx       = WIDX_W'(word_index);
		cmd.data       = data_word;
		cmd.start      = put_start;
		cmd.hit_count  = hitc_n;
		cmd.miss_count = missc_n;
		cmd.occupancy  = 5'(occ);
		if (take && is_get) cmd_valid = 1'b1;
		if (take && is_put && (put_start || (active_q && write_ok))) cmd_valid = 1'b1;
	end

	assign cap_new = (cfg_wdata == 5'd0) ? CNT_W'(1) :
		(cfg_wdata > 5'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cfg_wdata);
	always_comb
		for (int i = 0; i < ENTRIES; i++)
			evict[i] = valid_q[i] && (CNT_W'(rank_q[i]) >= cap_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
			hitc_q    <= '0;
			missc_q   <= '0;
			open_q    <= '0;
			active_q  <= 1'b0;
			cap_q     <= CNT_W'(ENTRIES);
			zeroing_q <= 1'b0;
		end else begin
			zeroing_q <= take && put_start;
			if (cfg_we) begin
				cap_q <= cap_new;
				for (int i = 0; i < ENTRIES; i++)
					if (evict[i]) begin valid_q[i] <= 1'b0; rank_q[i] <= '0; end
				if (active_q && evict[open_q]) active_q <= 1'b0;
			end else if (take) begin
				unique case (req_type)
					REQ_CLEAR: begin hitc_q <= '0; missc_q <= '0; end
					REQ_GET: begin
						hitc_q  <= hitc_n;
						missc_q <= missc_n;
						if (found)
							for (int i = 0; i < ENTRIES; i++)
								if (valid_q[i] && rank_q[i] < rank_q[found_slot])
									rank_q[i] <= rank_q[i] + SLOT_W'(1);
						if (found) rank_q[found_slot] <= '0;
					end
					REQ_PUT: begin
						if (put_start) begin
							for (int i = 0; i < ENTRIES; i++)
								if (valid_q[i] && (!(found || occ >= cap_q || !has_free)
									|| rank_q[i] < rank_q[sel_slot]))
									rank_q[i] <= rank_q[i] + SLOT_W'(1);
							rank_q[sel_slot]  <= '0;
							valid_q[sel_slot] <= 1'b1;
							open_q            <= sel_slot;
							active_q          <= !last_word;
						end else if (active_q && last_word) active_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk)
		if (!cfg_we && take && put_start) begin
			key_q[sel_slot] <= key;
			len_q[sel_slot] <= len_sat;
		end

	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) <= int'(cap_q))
		else $error("occupancy above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key held in two slots");
	assert property (@(posedge clk) disable iff (!arst_n)
		zeroing_q |-> !in_ready)
		else $error("input taken during slot zeroing");
endmodule
`default_nettype wire

### src/lsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_back: sector data store and result streamer
// Command queue, sector word memory with a clearing pass per put start, and
// an output register holding one result beat.
// ----------------------------------------------------------------------------
module lsc_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_valid,
	input  lsc_pkg::cmd_t          cmd,
	output logic                   cmd_ready,
	output logic                   empty,
	input  wire                    pop,
	output logic                   hit,
	output logic [63:0]            read_word,
	output logic [4:0]             read_index,
	output logic [8:0]             stored_length,
	output logic                   last,
	output logic [31:0]            hit_count,
	output logic [31:0]            miss_count,
	output logic [4:0]             occupancy
);
	import lsc_pkg::*;

	cmd_t                    q_mem [CMDQ_DEPTH];
	logic [CMDQ_AW:0]        wp_q, rp_q;
	logic                    q_empty, q_full;
	cmd_t                    head;

	logic [63:0]             mem [MEM_DEPTH];

	// slot clearing pass ahead of a put's first word
	logic                    clr_busy_q, clr_done_q;
	logic [WIDX_W-1:0]       clr_k_q;
	logic                    clr_go;
	logic                    wr_ok;

	// streaming state
	logic                    busy_q;
	cmd_t                    cur_q;
	logic [WIDX_W:0]         k_q, n_q;

	// read pipeline: s1 = memory read issued, s2 = output register
	logic                    v_s1;
	logic [63:0]             mask_s1;
	logic                    last_s1, hit_s1, zero_s1;
	logic [4:0]              idx_s1;
	cmd_t                    meta_s1;
	logic [63:0]             rd_s1;
	logic                    v_s2;

	logic                    adv, issue, deq;
	logic [WIDX_W:0]         n_words;
	logic [8:0]              avail;
	logic [9:0]              k_bytes;

	assign q_empty   = wp_q == rp_q;
	assign q_full    = (wp_q[CMDQ_AW] != rp_q[CMDQ_AW]) && (wp_q[CMDQ_AW-1:0] == rp_q[CMDQ_AW-1:0]);
	assign cmd_ready = !q_full;
	assign head      = q_mem[rp_q[CMDQ_AW-1:0]];

	// output stage may advance when slot free or being popped
	assign adv   = !v_s2 || pop;
	assign empty = !v_s2;

	// A put word executes at dequeue, a first word only once its slot is clear;
	// a get is latched and streamed.
	assign deq    = !q_empty && !busy_q && !clr_busy_q && (!head.is_get || adv)
		&& (head.is_get || !head.start || clr_done_q);
	assign clr_go = !q_empty && !busy_q && !clr_busy_q && !head.is_get && head.start
		&& !clr_done_q;
	assign issue  = busy_q && adv;
	assign wr_ok  = (9'(head.widx) * 9'(WORD_BYTES)) < head.length;

	always_comb begin
		n_words = (WIDX_W+1)'((head.length + 9'(WORD_BYTES - 1)) / WORD_BYTES);
		if (n_words == '0) n_words = (WIDX_W+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; busy_q <= 1'b0; k_q <= '0; n_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0;
			clr_busy_q <= 1'b0; clr_done_q <= 1'b0; clr_k_q <= '0;
		end else begin
			if (cmd_valid && cmd_ready) wp_q <= wp_q + (CMDQ_AW+1)'(1);
			if (clr_go) begin
				clr_busy_q <= 1'b1;
				clr_k_q    <= '0;
			end else if (clr_busy_q) begin
				clr_k_q <= clr_k_q + WIDX_W'(1);
				if (clr_k_q == WIDX_W'(WORDS_PER_SECTOR - 1)) begin
					clr_busy_q <= 1'b0;
					clr_done_q <= 1'b1;
				end
			end
			if (deq) begin
				rp_q       <= rp_q + (CMDQ_AW+1)'(1);
				clr_done_q <= 1'b0;
				if (head.is_get) begin
					busy_q <= 1'b1;
					k_q    <= '0;
					n_q    <= head.hit ? n_words : (WIDX_W+1)'(1);
				end
			end
			if (adv) begin
				v_s1 <= issue;
				if (issue) begin
					k_q <= k_q + (WIDX_W+1)'(1);
					if (k_q + (WIDX_W+1)'(1) == n_q) busy_q <= 1'b0;
				end
				v_s2 <= v_s1;
			end
		end
	end

	// clearing pass writes zeros, then put words write their data
	always_ff @(posedge clk)
		if (clr_busy_q)
			mem[{head.slot, clr_k_q}] <= '0;
		else if (deq && !head.is_get && wr_ok)
			mem[{head.slot, head.widx}] <= head.data;

	always_ff @(posedge clk)
		if (cmd_valid && cmd_ready) q_mem[wp_q[CMDQ_AW-1:0]] <= cmd;

	always_ff @(posedge clk)
		if (deq && head.is_get) cur_q <= head;

	always_comb begin
		k_bytes = 10'(k_q[WIDX_W-1:0]) * 10'(WORD_BYTES);
		avail   = ({1'b0, cur_q.length} > k_bytes) ? 9'({1'b0, cur_q.length} - k_bytes) : 9'd0;
	end

	always_ff @(posedge clk)
		if (adv && issue) begin
			rd_s1   <= mem[{cur_q.slot, k_q[WIDX_W-1:0]}];
			zero_s1 <= !cur_q.hit;
			for (int b = 0; b < 8; b++) mask_s1[b*8 +: 8] <= (avail > 9'(b)) ? 8'hFF : 8'h00;
			last_s1 <= k_q + (WIDX_W+1)'(1) == n_q;
			idx_s1  <= 5'(k_q);
			hit_s1  <= cur_q.hit;
			meta_s1 <= cur_q;
		end

	always_ff @(posedge clk)
		if (adv && v_s1) begin
			hit           <= hit_s1;
			read_word     <= zero_s1 ? 64'd0 : (rd_s1 & mask_s1);
			read_index    <= hit_s1 ? idx_s1 : 5'd0;
			stored_length <= hit_s1 ? meta_s1.length : 9'd0;
			last          <= last_s1;
			hit_count     <= meta_s1.hit_count;
			miss_count    <= meta_s1.miss_count;
			occupancy     <= meta_s1.occupancy;
		end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && cmd_valid && cmd_ready))
		else $error("push into full command queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> k_q < n_q)
		else $error("stream ran past its last beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !pop) |=> v_s2)
		else $error("result beat dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !deq)
		else $error("command taken during slot clear");
endmodule
`default_nettype wire

### src/lru_sector_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_sector_cache: fully associative LRU cache of disk sectors
// Top level joining the lookup front end and the data back end.
// ----------------------------------------------------------------------------
// A put's first word starts a clearing pass over its slot in the back end before
// any of its data is written. Put words are taken one per cycle, except the
// cycle right after the first word, until the four-deep command queue fills. A get
// is looked up in the cycle it is taken and, while the receiver pops, its result
// beats leave at one per cycle through a two-stage read of the sector memory; the
// next get leaves the queue only after the last beat of the earlier get is issued.
// A long hit stream or a slot clear fills the command queue and raises full. No
// clearing pass after reset.
module lru_sector_cache (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [4:0]   cfg_wdata,
	input  wire          push,
	output logic         full,
	input  wire  [1:0]   req_type,
	input  wire  [7:0]   track,
	input  wire  [7:0]   sector,
	input  wire  [4:0]   word_index,
	input  wire  [63:0]  data_word,
	input  wire  [8:0]   put_length,
	input  wire          last_word,
	output logic         empty,
	input  wire          pop,
	output logic         hit,
	output logic [63:0]  read_word,
	output logic [4:0]   read_index,
	output logic [8:0]   stored_length,
	output logic         last,
	output logic [31:0]  hit_count,
	output logic [31:0]  miss_count,
	output logic [4:0]   occupancy
);
	import lsc_pkg::*;

	logic  in_ready, cmd_valid, cmd_ready;
	cmd_t  cmd;

	assign full = !in_ready;

	lsc_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_valid(push), .in_ready,
		.req_type, .track, .sector, .word_index, .data_word, .put_length, .last_word,
		.cmd_valid, .cmd, .cmd_ready
	);

	lsc_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_ready,
		.empty, .pop, .hit, .read_word, .read_index, .stored_length, .last,
		.hit_count, .miss_count, .occupancy
	);
endmodule
`default_nettype wire

### dv/lsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_checker: result predictor and scoreboard of the LRU sector cache
// Watches the request, config and result channels, keeps its own copy of the
// cache contents and LRU order, and compares every result beat in order.
// ----------------------------------------------------------------------------
module lsc_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [4:0]   cfg_wdata,
	input  wire          push,
	input  wire          full,
	input  wire  [1:0]   req_type,
	input  wire  [7:0]   track,
	input  wire  [7:0]   sector,
	input  wire  [4:0]   word_index,
	input  wire  [63:0]  data_word,
	input  wire  [8:0]   put_length,
	input  wire          last_word,
	input  wire          empty,
	input  wire          pop,
	input  wire          hit,
	input  wire  [63:0]  read_word,
	input  wire  [4:0]   read_index,
	input  wire  [8:0]   stored_length,
	input  wire          last,
	input  wire  [31:0]  hit_count,
	input  wire  [31:0]  miss_count,
	input  wire  [4:0]   occupancy,
	output int           errors,
	output int           pending,
	output int           beats_seen,
	output int           hits_seen
);
	import lsc_pkg::*;

	typedef struct {
		logic        hit;
		logic [63:0] word;
		logic [4:0]  idx;
		logic [8:0]  len;
		logic        last;
		logic [31:0] hc;
		logic [31:0] mc;
		logic [4:0]  occ;
	} beat_t;

	beat_t       want_q[$];
	logic        c_valid [ENTRIES];
	logic [15:0] c_key   [ENTRIES];
	logic [8:0]  c_len   [ENTRIES];
	int          c_rank  [ENTRIES];
	logic [63:0] c_words [ENTRIES][WORDS_PER_SECTOR];
	logic [31:0] hits_n, misses_n;
	int          cap, put_slot;
	logic        put_open;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, exp);
		errors++;
	endtask

	function automatic int count_valid();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (c_valid[i]) n++;
		return n;
	endfunction

	function automatic int lookup(logic [15:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (c_valid[i] && c_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void make_recent(int s);
		int r;
		r = c_rank[s];
		for (int j = 0; j < ENTRIES; j++)
			if (c_valid[j] && c_rank[j] < r) c_rank[j]++;
		c_rank[s] = 0;
	endfunction

	function automatic logic [63:0] keep_bytes(int n);
		if (n >= 8) return '1;
		return (64'd1 << (n * 8)) - 64'd1;
	endfunction

	function automatic void open_put(logic [15:0] k, logic [8:0] plen);
		int s, br;
		s = lookup(k);
		if (s < 0) begin
			if (count_valid() < cap) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (!c_valid[j]) begin
						for (int i = 0; i < ENTRIES; i++)
							if (c_valid[i]) c_rank[i]++;
						c_valid[j] = 1'b1;
						c_rank[j] = 0;
						s = j;
						break;
					end
				end
			end else begin
				s = 0;
				br = 0;
				for (int j = 0; j < ENTRIES; j++)
					if (c_valid[j] && c_rank[j] >= br) begin
						br = c_rank[j];
						s = j;
					end
				make_recent(s);
			end
		end else begin
			make_recent(s);
		end
		c_key[s] = k;
		c_len[s] = (plen > SECTOR_BYTES) ? 9'(SECTOR_BYTES) : plen;
		for (int w = 0; w < WORDS_PER_SECTOR; w++)
			c_words[s][w] = '0;
		put_slot = s;
		put_open = 1'b1;
	endfunction

	function automatic void predict_request();
		logic [15:0] k;
		int s, n, occ, avail;
		beat_t b;
		k = {track, sector};
		case (req_t'(req_type))
			REQ_CLEAR: begin
				hits_n = '0;
				misses_n = '0;
			end
			REQ_PUT: begin
				if (word_index == 0) open_put(k, put_length);
				if (put_open) begin
					if (int'(word_index) * WORD_BYTES < c_len[put_slot])
						c_words[put_slot][word_index] = data_word;
					if (last_word) put_open = 1'b0;
				end
			end
			REQ_GET: begin
				s = lookup(k);
				if (s < 0) begin
					if (misses_n != '1) misses_n++;
					b = '{1'b0, 64'd0, 5'd0, 9'd0, 1'b1, hits_n, misses_n,
						5'(count_valid())};
					want_q.push_back(b);
				end else begin
					make_recent(s);
					if (hits_n != '1) hits_n++;
					n = (c_len[s] + WORD_BYTES - 1) / WORD_BYTES;
					if (n == 0) n = 1;
					if (n > WORDS_PER_SECTOR) n = WORDS_PER_SECTOR;
					occ = count_valid();
					for (int w = 0; w < n; w++) begin
						avail = int'(c_len[s]) - w * WORD_BYTES;
						if (avail < 0) avail = 0;
						b = '{1'b1, c_words[s][w] & keep_bytes(avail), 5'(w), c_len[s],
							(w + 1 == n), hits_n, misses_n, 5'(occ)};
						want_q.push_back(b);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void apply_capacity(logic [4:0] v);
		int c;
		c = v;
		if (c == 0) c = 1;
		if (c > ENTRIES) c = ENTRIES;
		cap = c;
		for (int j = 0; j < ENTRIES; j++)
			if (c_valid[j] && c_rank[j] >= c) begin
				c_valid[j] = 1'b0;
				c_rank[j] = 0;
				if (put_open && put_slot == j) put_open = 1'b0;
			end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q.delete();
			pending = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				c_valid[i] = 1'b0;
				c_rank[i] = 0;
			end
			hits_n = '0;
			misses_n = '0;
			cap = ENTRIES;
			put_slot = 0;
			put_open = 1'b0;
		end else begin
			if (!empty && pop) begin
				beats_seen++;
				if (want_q.size() == 0) begin
					$display("%0t unexpected result beat", $realtime);
					errors++;
				end else begin
					beat_t w;
					w = want_q.pop_front();
					if (w.hit) hits_seen++;
					if (hit !== w.hit) report_mismatch("hit", hit, w.hit);
					if (read_word !== w.word) report_mismatch("read_word", read_word, w.word);
					if (read_index !== w.idx) report_mismatch("read_index", read_index, w.idx);
					if (stored_length !== w.len)
						report_mismatch("stored_length", stored_length, w.len);
					if (last !== w.last) report_mismatch("last", last, w.last);
					if (hit_count !== w.hc) report_mismatch("hit_count", hit_count, w.hc);
					if (miss_count !== w.mc) report_mismatch("miss_count", miss_count, w.mc);
					if (occupancy !== w.occ) report_mismatch("occupancy", occupancy, w.occ);
				end
			end
			if (cfg_we) apply_capacity(cfg_wdata);
			if (push && !full) predict_request();
			pending = want_q.size();
		end
	end
endmodule

### dv/tb_lru_sector_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_sector_cache: testbench of the LRU sector cache
// Directed puts and gets over the corner cases, then random puts, gets and
// clears over a small key pool, under several idle/stall mixes and capacities.
// ----------------------------------------------------------------------------
module tb_lru_sector_cache;
	import lsc_pkg::*;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        push, full, empty, pop;
	logic [1:0]  req_type;
	logic [7:0]  track, sector;
	logic [4:0]  word_index;
	logic [63:0] data_word;
	logic [8:0]  put_length;
	logic        last_word;
	logic        hit, last;
	logic [63:0] read_word;
	logic [4:0]  read_index, occupancy;
	logic [8:0]  stored_length;
	logic [31:0] hit_count, miss_count;
	int          errors, pending, beats_seen, hits_seen;
	int          snd_idle_pct, rcv_idle_pct, hold_cycles, items_sent;
	logic        hold_go;

	lru_sector_cache i_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .push, .full, .req_type, .track, .sector,
		.word_index, .data_word, .put_length, .last_word, .empty, .pop, .hit,
		.read_word, .read_index, .stored_length, .last, .hit_count, .miss_count,
		.occupancy
	);

	lsc_checker i_checker (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .push, .full, .req_type, .track, .sector,
		.word_index, .data_word, .put_length, .last_word, .empty, .pop, .hit,
		.read_word, .read_index, .stored_length, .last, .hit_count, .miss_count,
		.occupancy, .errors, .pending, .beats_seen, .hits_seen
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_go) begin
			hold_cycles <= 300;
			pop <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_beat(req_t rq, logic [15:0] k, logic [4:0] wi, logic [63:0] d,
			logic [8:0] pl, logic lw);
		int gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= rq;
		{track, sector} <= k;
		word_index <= wi;
		data_word <= d;
		put_length <= pl;
		last_word <= lw;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic set_capacity(logic [4:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// full put of len bytes; extra adds one word beyond the length
	task automatic put_sector(logic [15:0] k, logic [8:0] len, bit extra);
		int n;
		n = (len + 7) / 8;
		if (n > WORDS_PER_SECTOR) n = WORDS_PER_SECTOR;
		if (extra && n < WORDS_PER_SECTOR) n++;
		if (n == 0) n = 1;
		for (int w = 0; w < n; w++)
			send_beat(REQ_PUT, k, 5'(w), rand64(), len, w == n - 1);
	endtask

	function automatic logic [15:0] pick_key();
		if ($urandom_range(9) == 0) return 16'($urandom);
		return {8'($urandom_range(2)), 8'($urandom_range(3))};
	endfunction

	task automatic random_run(int count);
		int sel, n, stop;
		logic [15:0] k;
		logic [8:0] len;
		repeat (count) begin
			sel = $urandom_range(99);
			k = pick_key();
			if (sel < 38) begin
				send_beat(REQ_GET, k, 5'($urandom), rand64(), 9'($urandom), 1'($urandom));
			end else if (sel < 80) begin
				case ($urandom_range(9))
					0: len = 9'($urandom);
					1: len = 9'(SECTOR_BYTES);
					default: len = 9'($urandom_range(40));
				endcase
				put_sector(k, len, $urandom_range(5) == 0);
			end else if (sel < 90) begin
				// broken put: stops early or wanders
				len = 9'($urandom_range(64));
				n = $urandom_range(5);
				stop = $urandom_range(1);
				for (int w = 0; w < n; w++)
					send_beat(REQ_PUT, 16'($urandom),
						(w == 0) ? 5'd0 : 5'($urandom), rand64(), len,
						stop && w == n - 1);
			end else if (sel < 94) begin
				send_beat(REQ_CLEAR, k, 5'($urandom), rand64(), 9'($urandom), 1'($urandom));
			end else if (sel < 97) begin
				send_beat(REQ_NONE, k, 5'($urandom), rand64(), 9'($urandom), 1'($urandom));
			end else begin
				send_beat(REQ_PUT, k, 5'($urandom_range(31, 1)), rand64(), 9'($urandom),
					1'($urandom));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		push <= 1'b0;
		hold_go <= 1'b0;
		req_type <= REQ_NONE;
		track <= '0;
		sector <= '0;
		word_index <= '0;
		data_word <= '0;
		put_length <= '0;
		last_word <= 1'b0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		items_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_beat(REQ_GET, 16'hFFFF, 5'd31, '1, 9'h1FF, 1'b1);      // miss, empty cache
		put_sector(16'hFFFF, 9'd256, 1'b0);                         // full sector
		send_beat(REQ_GET, 16'hFFFF, 5'd0, '0, 9'd0, 1'b0);
		put_sector(16'h0000, 9'd0, 1'b0);                           // empty sector
		send_beat(REQ_GET, 16'h0000, 5'd0, '0, 9'd0, 1'b0);
		put_sector(16'h0102, 9'd13, 1'b1);                          // partial, extra word
		send_beat(REQ_GET, 16'h0102, 5'd0, '0, 9'd0, 1'b0);
		put_sector(16'h0203, 9'h1FF, 1'b0);                         // length saturates
		send_beat(REQ_PUT, 16'h5555, 5'd3, '1, 9'd8, 1'b0);         // no open put
		send_beat(REQ_PUT, 16'h0304, 5'd0, '1, 9'd40, 1'b0);        // abandoned by next
		put_sector(16'h0405, 9'd9, 1'b0);
		send_beat(REQ_GET, 16'h0304, 5'd0, '0, 9'd0, 1'b0);
		send_beat(REQ_CLEAR, 16'h0, 5'd0, '0, 9'd0, 1'b0);
		send_beat(REQ_NONE, 16'hFFFF, 5'd31, '1, 9'h1FF, 1'b1);
		send_beat(REQ_GET, 16'h0203, 5'd0, '0, 9'd0, 1'b0);
		// open put slot evicted by a capacity drop
		send_beat(REQ_PUT, 16'h0A0A, 5'd0, '1, 9'd16, 1'b0);
		send_beat(REQ_GET, 16'h0405, 5'd0, '0, 9'd0, 1'b0);
		set_capacity(5'd1);
		send_beat(REQ_PUT, 16'h0A0A, 5'd1, '1, 9'd16, 1'b1);
		send_beat(REQ_GET, 16'h0A0A, 5'd0, '0, 9'd0, 1'b0);
		set_capacity(5'd0);
		put_sector(16'h0001, 9'd24, 1'b0);
		send_beat(REQ_GET, 16'h0405, 5'd0, '0, 9'd0, 1'b0);
		set_capacity(5'd31);

		// backpressure: long receiver hold while long hits queue up
		put_sector(16'h0101, 9'd256, 1'b0);
		wait_drained();
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (6) send_beat(REQ_GET, 16'h0101, 5'd0, '0, 9'd0, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  set_capacity(5'd16); end
				1: begin snd_idle_pct = 88; rcv_idle_pct = 0;  set_capacity(5'd3);  end
				2: begin snd_idle_pct = 0;  rcv_idle_pct = 88; set_capacity(5'd8);  end
				default: begin
					snd_idle_pct = 29; rcv_idle_pct = 29; set_capacity(5'd16);
				end
			endcase
			random_run(10);
		end

		wait_drained();
		$display("covered %0d request beats, %0d result beats (%0d hit beats)",
			items_sent, beats_seen, hits_seen);
		$display("capacity settings 0..31, idle mixes, long receiver hold-off");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

### lru_sector_cache.f
src/lsc_pkg.sv
src/lsc_front.sv
src/lsc_back.sv
src/lru_sector_cache.sv
dv/lsc_checker.sv
dv/tb_lru_sector_cache.sv
